### design/vvp_pkg.sv
// Package for the vertex view projection block: fixed-point constants,
// datapath widths and configuration register indexes.
// Used by vvp_div and vertex_view_projection; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package vvp_pkg;

    // Q16.16 near limit (0.1) and 1/tan(60 deg) in Q0.16
    localparam int NEAR_Z          = 6554;
    localparam int INV_TAN60       = 37837;
    localparam int CLAMP_MARGIN_Q4 = 16000;
    localparam int OUT_MAX         = 131071;

    // divider numerator, denominator and quotient bits
    localparam int NW = 68;
    localparam int DW = 49;
    localparam int QB = 19;

    typedef enum logic [3:0] {
        CFG_CAM_X      = 4'd0,
        CFG_CAM_Y      = 4'd1,
        CFG_CAM_Z      = 4'd2,
        CFG_COS_YAW    = 4'd3,
        CFG_SIN_YAW    = 4'd4,
        CFG_COS_PITCH  = 4'd5,
        CFG_SIN_PITCH  = 4'd6,
        CFG_VIEW_WIDTH = 4'd7
    } t_cfg_idx;

endpackage
`default_nettype wire

### design/vvp_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating.
// Depends on vvp_pkg for the numerator, denominator and quotient widths.
`timescale 1ns / 1ps
`default_nettype none
module vvp_div #(
    parameter int SW = 1
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire  [vvp_pkg::NW-1:0]       i_num,
    input  wire  [vvp_pkg::DW-1:0]       i_den,
    input  wire  [SW-1:0]                i_side,
    output logic                         o_valid,
    output logic [vvp_pkg::QB:0]         o_quot,
    output logic [SW-1:0]                o_side
);
    localparam int NW = vvp_pkg::NW;
    localparam int DW = vvp_pkg::DW;
    localparam int QB = vvp_pkg::QB;

    logic [NW-1:0] r_rem   [0:QB-1];
    logic [DW-1:0] r_d     [0:QB-1];
    logic [QB-1:0] r_q     [0:QB];
    logic          r_sat   [0:QB];
    logic          r_valid [0:QB];
    logic [SW-1:0] r_side  [0:QB];

    logic [NW-1:0] w_top;
    assign w_top = {{(NW-DW){1'b0}}, i_den} << QB;

    // stage 0: flag quotients that do not fit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_d[0]    <= i_den;
            r_q[0]    <= '0;
            r_sat[0]  <= (i_num >= w_top);
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_stage
        localparam int K = QB - j;
        logic [NW-1:0] w_trial;
        logic          w_bit;
        assign w_trial = {{(NW-DW){1'b0}}, r_d[j-1]} << K;
        assign w_bit   = (r_rem[j-1] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= r_valid[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j]    <= {r_q[j-1][QB-2:0], w_bit};
                r_sat[j]  <= r_sat[j-1];
                r_side[j] <= r_side[j-1];
            end
        end

        if (j < QB) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_bit ? (r_rem[j-1] - w_trial) : r_rem[j-1];
                    r_d[j]   <= r_d[j-1];
                end
            end
        end
    end

    assign o_valid = r_valid[QB];
    assign o_quot  = r_sat[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, r_q[QB]};
    assign o_side  = r_side[QB];

endmodule
`default_nettype wire

### design/vertex_view_projection.sv
// Top level of the vertex view projection block: camera registers,
// rotation and projection pipeline. Depends on vvp_pkg and vvp_div.
`timescale 1ns / 1ps
`default_nettype none
// One world vertex (Q16.16) in, one screen point (Q.4 pixels) out. The block
// takes one item every cycle unless held, and each item passes through nine
// stages of offset, yaw and pitch rotation, near clamp and scaling, twenty
// stages of the pipelined divider (one quotient bit a stage) and the output
// register that offsets and saturates. The whole pipeline advances together;
// it holds only while a finished item waits at the output and the sink
// stalls, so o_in_stall follows i_out_stall in that case. Configuration
// registers are written through i_cfg_we/i_cfg_idx/i_cfg_data and must only
// change while no item is in flight; an index beyond the list is dropped.
module vertex_view_projection #(
    parameter int VIEW_HEIGHT = 720
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [3:0]         i_cfg_idx,
    input  wire  [31:0]        i_cfg_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  signed [31:0] i_vertex_x,
    input  wire  signed [31:0] i_vertex_y,
    input  wire  signed [31:0] i_vertex_z,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [17:0] o_screen_x,
    output logic signed [17:0] o_screen_y,
    output logic signed [31:0] o_view_depth,
    output logic               o_near_clamped
);
    localparam int NW = vvp_pkg::NW;
    localparam int DW = vvp_pkg::DW;
    localparam int QB = vvp_pkg::QB;
    localparam int HI_Y_RAW = (VIEW_HEIGHT + 1000) * 16;
    localparam int HI_Y  = (HI_Y_RAW > vvp_pkg::OUT_MAX) ? vvp_pkg::OUT_MAX : HI_Y_RAW;
    localparam int OFF_Y = VIEW_HEIGHT * 8;

    // ---------------- configuration registers ----------------
    logic signed [31:0] r_cam_x, r_cam_y, r_cam_z;
    logic signed [15:0] r_cos_yaw, r_sin_yaw, r_cos_pitch, r_sin_pitch;
    logic        [12:0] r_view_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x      <= '0;
            r_cam_y      <= '0;
            r_cam_z      <= '0;
            r_cos_yaw    <= 16'sd16384;
            r_sin_yaw    <= '0;
            r_cos_pitch  <= 16'sd16384;
            r_sin_pitch  <= '0;
            r_view_width <= 13'd1280;
        end else if (i_cfg_we) begin
            case (vvp_pkg::t_cfg_idx'(i_cfg_idx))
                vvp_pkg::CFG_CAM_X:      r_cam_x      <= i_cfg_data;
                vvp_pkg::CFG_CAM_Y:      r_cam_y      <= i_cfg_data;
                vvp_pkg::CFG_CAM_Z:      r_cam_z      <= i_cfg_data;
                vvp_pkg::CFG_COS_YAW:    r_cos_yaw    <= i_cfg_data[15:0];
                vvp_pkg::CFG_SIN_YAW:    r_sin_yaw    <= i_cfg_data[15:0];
                vvp_pkg::CFG_COS_PITCH:  r_cos_pitch  <= i_cfg_data[15:0];
                vvp_pkg::CFG_SIN_PITCH:  r_sin_pitch  <= i_cfg_data[15:0];
                vvp_pkg::CFG_VIEW_WIDTH: r_view_width <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Advance everything unless a finished item is held at the output.
    logic r_vo;
    logic w_en;
    assign w_en       = !(r_vo && i_out_stall);
    assign o_in_stall = !w_en;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9;
    logic w_dvx, w_dvy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_v6 <= 1'b0;
            r_v7 <= 1'b0; r_v8 <= 1'b0; r_v9 <= 1'b0;
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
            r_v5 <= r_v4; r_v6 <= r_v5; r_v7 <= r_v6;
            r_v8 <= r_v7; r_v9 <= r_v8;
            r_vo <= w_dvx;
        end
    end

    // ---------------- stage 1: camera offset (exact, 33 bit) ----------------
    logic signed [32:0] r1_dx, r1_dy, r1_dz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx <= $signed({i_vertex_x[31], i_vertex_x}) - $signed({r_cam_x[31], r_cam_x});
            r1_dy <= $signed({i_vertex_y[31], i_vertex_y}) - $signed({r_cam_y[31], r_cam_y});
            r1_dz <= $signed({i_vertex_z[31], i_vertex_z}) - $signed({r_cam_z[31], r_cam_z});
        end
    end

    // ---------------- stage 2: yaw products ----------------
    logic signed [48:0] r2_pxc, r2_pzs, r2_pxs, r2_pzc;
    logic signed [32:0] r2_dy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pxc <= r1_dx * r_cos_yaw;
            r2_pzs <= r1_dz * r_sin_yaw;
            r2_pxs <= r1_dx * r_sin_yaw;
            r2_pzc <= r1_dz * r_cos_yaw;
            r2_dy  <= r1_dy;
        end
    end

    // ---------------- stage 3: yaw sums, round to Q16.16 ----------------
    logic signed [50:0] w3_xs, w3_zs, w3_xr, w3_zr;
    assign w3_xs = r2_pxc - r2_pzs;
    assign w3_zs = r2_pxs + r2_pzc;
    assign w3_xr = (w3_xs + 51'sd8192) >>> 14;
    assign w3_zr = (w3_zs + 51'sd8192) >>> 14;

    logic signed [36:0] r3_xr, r3_zr;
    logic signed [32:0] r3_dy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_xr <= w3_xr[36:0];
            r3_zr <= w3_zr[36:0];
            r3_dy <= r2_dy;
        end
    end

    // ---------------- stage 4: pitch products ----------------
    logic signed [52:0] r4_pyc, r4_pzs, r4_pys, r4_pzc;
    logic signed [36:0] r4_xr;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_pyc <= r3_dy * r_cos_pitch;
            r4_pzs <= r3_zr * r_sin_pitch;
            r4_pys <= r3_dy * r_sin_pitch;
            r4_pzc <= r3_zr * r_cos_pitch;
            r4_xr  <= r3_xr;
        end
    end

    // ---------------- stage 5: pitch sums ----------------
    logic signed [53:0] w5_ys, w5_zs, w5_yr, w5_zz;
    assign w5_ys = r4_pyc - r4_pzs;
    assign w5_zs = r4_pys + r4_pzc;
    assign w5_yr = (w5_ys + 54'sd8192) >>> 14;
    assign w5_zz = (w5_zs + 54'sd8192) >>> 14;

    logic signed [39:0] r5_yr, r5_zz;
    logic signed [36:0] r5_xr;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_yr <= w5_yr[39:0];
            r5_zz <= w5_zz[39:0];
            r5_xr <= r4_xr;
        end
    end

    // ---------------- stage 6: near clamp, depth saturation, 1/tan ----------------
    logic               w6_clamp;
    logic signed [39:0] w6_depth;
    logic signed [31:0] w6_vd;
    logic signed [16:0] w6_inv;
    assign w6_inv   = 17'(vvp_pkg::INV_TAN60);
    assign w6_clamp = (r5_zz < 40'sd6554);
    assign w6_depth = w6_clamp ? 40'(vvp_pkg::NEAR_Z) : r5_zz;

    always_comb begin
        if (r5_zz > 40'sd2147483647) begin
            w6_vd = 32'sh7fffffff;
        end else if (r5_zz < -40'sd2147483648) begin
            w6_vd = 32'sh80000000;
        end else begin
            w6_vd = r5_zz[31:0];
        end
    end

    logic signed [56:0] r6_mx, r6_my;
    logic [DW-1:0]      r6_den;
    logic signed [31:0] r6_vd;
    logic               r6_clamp;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_mx    <= r5_xr * w6_inv;
            r6_my    <= r5_yr * w6_inv;
            r6_den   <= {{(DW-47){1'b0}}, w6_depth[38:0], 8'd0};
            r6_vd    <= w6_vd;
            r6_clamp <= w6_clamp;
        end
    end

    // ---------------- stage 7: round to Q.24 ----------------
    logic signed [56:0] w7_sx, w7_sy;
    assign w7_sx = (r6_mx + 57'sd128) >>> 8;
    assign w7_sy = (r6_my + 57'sd128) >>> 8;

    logic signed [48:0] r7_scx, r7_scy;
    logic [DW-1:0]      r7_den;
    logic signed [31:0] r7_vd;
    logic               r7_clamp;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_scx   <= w7_sx[48:0];
            r7_scy   <= w7_sy[48:0];
            r7_den   <= r6_den;
            r7_vd    <= r6_vd;
            r7_clamp <= r6_clamp;
        end
    end

    // ---------------- stage 8: scale by width*16 (both axes) ----------------
    logic signed [17:0] w8_scale;
    assign w8_scale = $signed({1'b0, r_view_width, 4'd0});

    logic signed [66:0] r8_ax, r8_ay;
    logic [DW-1:0]      r8_den;
    logic signed [31:0] r8_vd;
    logic               r8_clamp;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_ax    <= r7_scx * w8_scale;
            r8_ay    <= r7_scy * w8_scale;
            r8_den   <= r7_den;
            r8_vd    <= r7_vd;
            r8_clamp <= r7_clamp;
        end
    end

    // ---------------- stage 9: magnitude and rounding bias ----------------
    // q = (2|a| + den) / (2 den) rounds to nearest, ties away from zero.
    logic [66:0] w9_magx, w9_magy;
    assign w9_magx = r8_ax[66] ? 67'(-r8_ax) : 67'(r8_ax);
    assign w9_magy = r8_ay[66] ? 67'(-r8_ay) : 67'(r8_ay);

    logic [NW-1:0]      r9_nx, r9_ny;
    logic [DW-1:0]      r9_d;
    logic               r9_negx, r9_negy;
    logic signed [31:0] r9_vd;
    logic               r9_clamp;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_nx    <= {w9_magx, 1'b0} + {{(NW-DW){1'b0}}, r8_den};
            r9_ny    <= {w9_magy, 1'b0} + {{(NW-DW){1'b0}}, r8_den};
            r9_d     <= {r8_den[DW-2:0], 1'b0};
            r9_negx  <= r8_ax[66];
            r9_negy  <= r8_ay[66];
            r9_vd    <= r8_vd;
            r9_clamp <= r8_clamp;
        end
    end

    // ---------------- stages 10-29: dividers ----------------
    logic [QB:0]  w_qx, w_qy;
    logic [33:0]  w_sidex;
    logic [0:0]   w_sidey;

    vvp_div #(.SW(34)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v9),
        .i_num   (r9_nx),
        .i_den   (r9_d),
        .i_side  ({r9_negx, r9_clamp, r9_vd}),
        .o_valid (w_dvx),
        .o_quot  (w_qx),
        .o_side  (w_sidex)
    );

    vvp_div #(.SW(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v9),
        .i_num   (r9_ny),
        .i_den   (r9_d),
        .i_side  (r9_negy),
        .o_valid (w_dvy),
        .o_quot  (w_qy),
        .o_side  (w_sidey)
    );

    // ---------------- stage 30: offset and saturate ----------------
    logic signed [21:0] w_qsx, w_qsy, w_sx, w_sy, w_hix, w_cx, w_cy;
    logic        [17:0] w_hix_raw;
    assign w_qsx = w_sidex[33] ? -$signed({2'b0, w_qx}) : $signed({2'b0, w_qx});
    assign w_qsy = w_sidey[0]  ? -$signed({2'b0, w_qy}) : $signed({2'b0, w_qy});
    assign w_sx  = w_qsx + $signed({6'd0, r_view_width, 3'd0});
    assign w_sy  = w_qsy + 22'(OFF_Y);
    assign w_hix_raw = {(5'd0 + r_view_width) + 14'd1000, 4'd0};
    assign w_hix = (w_hix_raw > 18'(vvp_pkg::OUT_MAX)) ? 22'(vvp_pkg::OUT_MAX)
                                                       : $signed({4'd0, w_hix_raw});

    always_comb begin
        if (w_sx < -22'(vvp_pkg::CLAMP_MARGIN_Q4)) begin
            w_cx = -22'(vvp_pkg::CLAMP_MARGIN_Q4);
        end else if (w_sx > w_hix) begin
            w_cx = w_hix;
        end else begin
            w_cx = w_sx;
        end
        if (w_sy < -22'(vvp_pkg::CLAMP_MARGIN_Q4)) begin
            w_cy = -22'(vvp_pkg::CLAMP_MARGIN_Q4);
        end else if (w_sy > 22'(HI_Y)) begin
            w_cy = 22'(HI_Y);
        end else begin
            w_cy = w_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_screen_x     <= w_cx[17:0];
            o_screen_y     <= w_cy[17:0];
            o_view_depth   <= w_sidex[31:0];
            o_near_clamped <= w_sidex[32];
        end
    end

    assign o_out_valid = r_vo;

    // ---------------- assertions ----------------
    a_clamp_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_near_clamped) |-> (o_view_depth < 32'sd6554))
        else $error("near flag set on a depth at or beyond the near limit");

    a_noclamp_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_near_clamped) |-> (o_view_depth >= 32'sd6554))
        else $error("depth below the near limit without the near flag");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_screen_y >= -18'sd16000) && (o_screen_y <= 18'(HI_Y))))
        else $error("screen y outside the saturation range");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dvx == w_dvy)
        else $error("x and y dividers out of step");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output item present after reset");

endmodule
`default_nettype wire
